>>> hdl/cwt_pkg.sv
package cwt_pkg;

    // Action codes carried on the input word.
    localparam logic [1:0] ACT_SAVE      = 2'd0;
    localparam logic [1:0] ACT_DELETE    = 2'd1;
    localparam logic [1:0] ACT_RECOGNIZE = 2'd2;

    // Status codes carried on the output word.
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    localparam int ACT_W    = 2;
    localparam int NAME_W   = 8;
    localparam int SERIAL_W = 32;
    localparam int ECOUNT_W = 5;

    typedef logic [ACT_W-1:0]    t_action;
    typedef logic [NAME_W-1:0]   t_name;
    typedef logic [SERIAL_W-1:0] t_serial;
    typedef logic [ECOUNT_W-1:0] t_ecount;

    // One table slot as it is stored in the table memory.
    typedef struct packed {
        t_name   name;
        t_serial serial;
        logic    active;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

>>> hdl/cwt_ifs.sv
interface cwt_in_if;
    import cwt_pkg::*;

    logic    valid;
    logic    ready;
    t_action action;
    t_name   card_name;
    t_serial card_serial;

    modport source (output valid, output action, output card_name, output card_serial,
                    input ready);
    modport sink   (input valid, input action, input card_name, input card_serial,
                    output ready);
endinterface

interface cwt_out_if;
    import cwt_pkg::*;

    logic    valid;
    logic    ready;
    logic    status;
    t_ecount entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

>>> hdl/cwt_ram.sv
module cwt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 41,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/card_id_whitelist_table_unit.sv
// Channel   Dir  Payload                                   Handshake
// i_in      in   action, card_name, card_serial            valid / ready
// o_out     out  status, entry_count                       valid / ready
//
// An accepted item scans the used slots in order, then waits in a done state until
// the output word is free, hands its result out and returns to idle, where the next
// word can be taken; an empty table reads no slot. A save that finds its serial, or
// a delete or recognize that hits, ends the scan at the matching slot. The single
// read port of the table memory reads one slot per cycle while scanning. Reset
// clears the used count, the state, the pending flag and the output valid flag and
// holds ready low; slot contents stay undefined and are never read before they
// are written. A stalled output holds its word; a new item is accepted while that
// word still waits, and once finished it holds the input off until the word leaves.
module card_id_whitelist_table_unit #(
    parameter int CAPACITY = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cwt_in_if.sink   i_in,
    cwt_out_if.source o_out
);
    import cwt_pkg::*;

    // Slot index width and used-count width; the count must be able to hold CAPACITY.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]    r_state, n_state;
    t_action       r_act;
    t_name         r_name;
    t_serial       r_serial;
    logic [CW-1:0] r_count, n_count;
    // Next slot to read, and the slot whose data arrives from the memory this cycle.
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_pend, n_pend;
    logic [CW-1:0] r_pidx, n_pidx;
    logic          r_fail, n_fail;
    logic          r_ovalid, n_ovalid;
    logic          r_ostatus, n_ostatus;
    t_ecount       r_ocount, n_ocount;

    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    t_entry        rd_entry;
    logic [ENTRY_W-1:0] rd_raw;
    logic          hit;
    logic          accept;

    cwt_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_W),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (rd_raw)
    );

    assign rd_entry = t_entry'(rd_raw);
    assign accept   = i_in.valid && i_in.ready;

    // A save matches on serial regardless of the active flag, a delete on name,
    // and a recognize only on an active slot with the serial.
    always_comb begin
        case (r_act)
            ACT_SAVE:      hit = (rd_entry.serial == r_serial);
            ACT_DELETE:    hit = (rd_entry.name == r_name);
            ACT_RECOGNIZE: hit = rd_entry.active && (rd_entry.serial == r_serial);
            default:       hit = 1'b0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_pend    = r_pend;
        n_pidx    = r_pidx;
        n_fail    = r_fail;
        n_ovalid  = r_ovalid;
        n_ostatus = r_ostatus;
        n_ocount  = r_ocount;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_count[AW-1:0];
        wr_data   = '{name: r_name, serial: r_serial, active: 1'b1};

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ptr   = '0;
                    n_pend  = 1'b0;
                    n_fail  = ST_FAIL;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_pend && hit) begin
                    n_state = S_DONE;
                    if (r_act == ACT_SAVE) begin
                        n_fail = ST_FAIL;
                    end else begin
                        n_fail = ST_OK;
                    end
                    if (r_act == ACT_DELETE) begin
                        wr_en   = 1'b1;
                        wr_addr = r_pidx[AW-1:0];
                        wr_data = '{name: rd_entry.name, serial: rd_entry.serial,
                                    active: 1'b0};
                        if (CW'(r_pidx + 1'b1) == r_count) begin
                            n_count = CW'(r_count - 1'b1);
                        end
                    end
                end else if (!r_pend && (r_ptr >= r_count)) begin
                    // Scan ran out without a match.
                    n_state = S_DONE;
                    if ((r_act == ACT_SAVE) && (r_count < CAP_C)) begin
                        wr_en   = 1'b1;
                        n_count = CW'(r_count + 1'b1);
                        n_fail  = ST_OK;
                    end else begin
                        n_fail  = ST_FAIL;
                    end
                end else begin
                    if (r_ptr < r_count) begin
                        rd_en  = 1'b1;
                        n_ptr  = CW'(r_ptr + 1'b1);
                        n_pidx = r_ptr;
                        n_pend = 1'b1;
                    end else begin
                        n_pend = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_fail;
                    n_ocount  = ECOUNT_W'(r_count);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act    <= i_in.action;
            r_name   <= i_in.card_name;
            r_serial <= i_in.card_serial;
        end
        r_ptr     <= n_ptr;
        r_pidx    <= n_pidx;
        r_fail    <= n_fail;
        r_ostatus <= n_ostatus;
        r_ocount  <= n_ocount;
    end

    // No word is taken while reset is held.
    assign i_in.ready        = i_rst_n && (r_state == S_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.status      = r_ostatus;
    assign o_out.entry_count = r_ocount;

endmodule

>>> hdl/cwt_checker.sv
module cwt_checker #(
    parameter int CAPACITY = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_status,
    input logic [4:0] i_out_count
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_status) && $stable(i_out_count)))
        else $error("output word changed while stalled");

    // The used count never goes past the table size.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((CAPACITY > 31) || (i_out_count <= 5'(CAPACITY))))
        else $error("entry count above capacity");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while an item is in work");

    // A result never shows up in the cycle right after its item was taken.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=>
            !(i_out_valid && !($past(i_out_valid) && !$past(i_out_ready))))
        else $error("result word appeared too early");

endmodule

bind card_id_whitelist_table_unit cwt_checker #(
    .CAPACITY (CAPACITY)
) u_cwt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_count  (o_out.entry_count)
);
